### design/nsd_pkg.sv
package nsd_pkg;

	// request kinds
	typedef enum logic [1:0] {
		REQ_TIME  = 2'd0,
		REQ_FOUR  = 2'd1,
		REQ_SIX   = 2'd2,
		REQ_CLEAR = 2'd3
	} req_t;

	localparam logic [3:0] BLANK_SYMBOL   = 4'd10;
	localparam logic [6:0] BLANK_SEGMENTS = 7'h7F;
	localparam logic [2:0] COUNT_MIN      = 3'd4;
	localparam logic [2:0] COUNT_MAX      = 3'd6;
	localparam int         NUM_DIGITS     = 6;

	// one display request as it enters the pipeline
	typedef struct packed {
		req_t        req;
		logic [31:0] number_value;
		logic [7:0]  high_pair;
		logic [7:0]  low_pair;
	} request_t;

	// reduced value, below one million
	typedef struct packed {
		req_t        req;
		logic [19:0] value;
	} reduced_t;

	// six decimal digits, index 0 is the most significant
	typedef struct packed {
		req_t                            req;
		logic [NUM_DIGITS-1:0][3:0]      dig;
	} digits_t;

	// finished display frame, index 0 is the leftmost position
	typedef struct packed {
		logic [NUM_DIGITS-1:0][3:0]      sym;
		logic [NUM_DIGITS-1:0]           sep;
	} frame_t;

	// active-low segments g..a for a symbol, blank for anything else
	function automatic logic [6:0] seg_of(input logic [3:0] sym);
		logic [6:0] seg;
		case (sym)
			4'd0:    seg = 7'h40;
			4'd1:    seg = 7'h79;
			4'd2:    seg = 7'h24;
			4'd3:    seg = 7'h30;
			4'd4:    seg = 7'h19;
			4'd5:    seg = 7'h12;
			4'd6:    seg = 7'h02;
			4'd7:    seg = 7'h78;
			4'd8:    seg = 7'h00;
			4'd9:    seg = 7'h10;
			default: seg = BLANK_SEGMENTS;
		endcase
		return seg;
	endfunction

endpackage

### design/nsd_reduce.sv
module nsd_reduce (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  nsd_pkg::request_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output nsd_pkg::reduced_t out_data
);

	// reciprocals: q = (x * M) >> K is exact for every 32-bit x
	localparam logic [31:0] RECIP_FOUR = 32'd3518437209;   // 2^45 / 10000, rounded up
	localparam logic [31:0] RECIP_SIX  = 32'd1125899907;   // 2^50 / 1000000, rounded up
	localparam logic [20:0] DIV_FOUR   = 21'd10000;
	localparam logic [20:0] DIV_SIX    = 21'd1000000;

	function automatic logic [5:0] mod60(input logic [7:0] x);
		logic [7:0] r;
		if (x >= 8'd240)
			r = x - 8'd240;
		else if (x >= 8'd180)
			r = x - 8'd180;
		else if (x >= 8'd120)
			r = x - 8'd120;
		else if (x >= 8'd60)
			r = x - 8'd60;
		else
			r = x;
		return r[5:0];
	endfunction

	logic               vld_s1, vld_s2, vld_s3;
	logic               en1, en2, en3;
	nsd_pkg::req_t      req_s1, req_s2, req_s3;
	logic [31:0]        num_s1;
	logic [20:0]        num_s2;
	logic [18:0]        quo_s1;
	logic [20:0]        qd_s2;
	logic [13:0]        tv_s1, tv_s2;
	logic [19:0]        value_s3;

	logic [63:0]        prod1;
	logic [31:0]        recip;
	logic [13:0]        tv;
	logic [38:0]        prod2;
	logic [20:0]        div2, div3;
	logic [20:0]        rem3;

	// advance a stage when it is empty or its word moves on
	assign en3 = !vld_s3 || out_ready;
	assign en2 = !vld_s2 || en3;
	assign en1 = !vld_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (en1)
				vld_s1 <= in_valid;
			if (en2)
				vld_s2 <= vld_s1;
			if (en3)
				vld_s3 <= vld_s2;
		end
	end

	// stage 1: reciprocal multiply, time pairs folded into MMSS
	assign recip = (in_data.req == nsd_pkg::REQ_SIX) ? RECIP_SIX : RECIP_FOUR;
	assign prod1 = 64'(in_data.number_value) * 64'(recip);
	assign tv    = 14'(mod60(in_data.high_pair)) * 14'd100 + 14'(mod60(in_data.low_pair));

	always_ff @(posedge clk) begin
		if (en1) begin
			req_s1 <= in_data.req;
			num_s1 <= in_data.number_value;
			tv_s1  <= tv;
			quo_s1 <= (in_data.req == nsd_pkg::REQ_SIX) ? 19'(prod1[63:50]) : prod1[63:45];
		end
	end

	// stage 2: multiply the quotient back; the remainder fits in 21 bits
	assign div2  = (req_s1 == nsd_pkg::REQ_SIX) ? DIV_SIX : DIV_FOUR;
	assign prod2 = 39'(quo_s1) * 39'(div2);

	always_ff @(posedge clk) begin
		if (en2) begin
			req_s2 <= req_s1;
			num_s2 <= num_s1[20:0];
			qd_s2  <= prod2[20:0];
			tv_s2  <= tv_s1;
		end
	end

	// stage 3: subtract and correct once
	assign div3 = (req_s2 == nsd_pkg::REQ_SIX) ? DIV_SIX : DIV_FOUR;
	assign rem3 = num_s2 - qd_s2;

	always_ff @(posedge clk) begin
		if (en3) begin
			req_s3 <= req_s2;
			if (req_s2 == nsd_pkg::REQ_TIME)
				value_s3 <= 20'(tv_s2);
			else if (rem3 >= div3)
				value_s3 <= 20'(rem3 - div3);
			else
				value_s3 <= rem3[19:0];
		end
	end

	assign out_valid      = vld_s3;
	assign out_data.req   = req_s3;
	assign out_data.value = value_s3;

endmodule

### design/nsd_split.sv
module nsd_split (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  nsd_pkg::reduced_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output nsd_pkg::digits_t  out_data
);

	// 2^30 / 1000, rounded up: exact for every 20-bit value
	localparam logic [20:0] RECIP_THOUSAND = 21'd1073742;

	// three decimal digits of a value below 1000, hundreds first
	function automatic logic [11:0] bcd3(input logic [9:0] x);
		logic [15:0] ph;
		logic [3:0]  h;
		logic [9:0]  hm;
		logic [6:0]  r;
		logic [13:0] pt;
		logic [3:0]  t;
		logic [6:0]  tm;
		logic [3:0]  u;
		ph = 16'(x) * 16'd41;
		h  = ph[15:12];
		hm = 10'(h) * 10'd100;
		r  = 7'(x - hm);
		pt = 14'(r) * 14'd103;
		t  = pt[13:10];
		tm = 7'(t) * 7'd10;
		u  = 4'(r - tm);
		return {h, t, u};
	endfunction

	logic                 vld_s4, vld_s5, vld_s6;
	logic                 en4, en5, en6;
	nsd_pkg::req_t        req_s4, req_s5, req_s6;
	logic [19:0]          v_s4;
	logic [9:0]           a_s4, a_s5, b_s5;
	logic [5:0][3:0]      dig_s6;

	logic [40:0]          prod4;
	logic [19:0]          am5;
	logic [11:0]          hi6, lo6;

	// advance a stage when it is empty or its word moves on
	assign en6 = !vld_s6 || out_ready;
	assign en5 = !vld_s5 || en6;
	assign en4 = !vld_s4 || en5;
	assign in_ready = en4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (en4)
				vld_s4 <= in_valid;
			if (en5)
				vld_s5 <= vld_s4;
			if (en6)
				vld_s6 <= vld_s5;
		end
	end

	// stage 4: upper three digits as value / 1000
	assign prod4 = 41'(in_data.value) * 41'(RECIP_THOUSAND);

	always_ff @(posedge clk) begin
		if (en4) begin
			req_s4 <= in_data.req;
			v_s4   <= in_data.value;
			a_s4   <= prod4[39:30];
		end
	end

	// stage 5: lower three digits as the remainder
	assign am5 = 20'(a_s4) * 20'd1000;

	always_ff @(posedge clk) begin
		if (en5) begin
			req_s5 <= req_s4;
			a_s5   <= a_s4;
			b_s5   <= v_s4[9:0] - am5[9:0];
		end
	end

	// stage 6: each half into decimal digits
	assign hi6 = bcd3(a_s5);
	assign lo6 = bcd3(b_s5);

	always_ff @(posedge clk) begin
		if (en6) begin
			req_s6    <= req_s5;
			dig_s6[0] <= hi6[11:8];
			dig_s6[1] <= hi6[7:4];
			dig_s6[2] <= hi6[3:0];
			dig_s6[3] <= lo6[11:8];
			dig_s6[4] <= lo6[7:4];
			dig_s6[5] <= lo6[3:0];
		end
	end

	assign out_valid    = vld_s6;
	assign out_data.req = req_s6;
	assign out_data.dig = dig_s6;

endmodule

### design/nsd_format.sv
module nsd_format (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  nsd_pkg::digits_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output nsd_pkg::frame_t  out_data
);

	logic             vld_s7;
	logic             en7;
	nsd_pkg::frame_t  frame_s7;
	nsd_pkg::frame_t  frame;
	logic [2:0]       span;
	logic             lead;

	assign en7      = !vld_s7 || out_ready;
	assign in_ready = en7;

	// place digits by mode, then blank leading zeros
	always_comb begin
		frame.sym = {nsd_pkg::NUM_DIGITS{nsd_pkg::BLANK_SYMBOL}};
		frame.sep = '0;
		span      = 3'd0;
		case (in_data.req)
			nsd_pkg::REQ_TIME: begin
				for (int i = 0; i < 4; i++)
					frame.sym[i] = in_data.dig[i+2];
				frame.sep[1] = 1'b1;
				span         = 3'd4;
			end
			nsd_pkg::REQ_FOUR: begin
				for (int i = 0; i < 4; i++)
					frame.sym[i] = in_data.dig[i+2];
				span = 3'd4;
			end
			nsd_pkg::REQ_SIX: begin
				frame.sym = in_data.dig;
				span      = 3'd6;
			end
			default: begin
				span = 3'd0;
			end
		endcase
		lead = 1'b1;
		for (int i = 0; i < nsd_pkg::NUM_DIGITS - 1; i++) begin
			if (lead && ((3'(i) + 3'd1) < span)) begin
				if (frame.sep[i] || (frame.sym[i] != 4'd0))
					lead = 1'b0;
				else
					frame.sym[i] = nsd_pkg::BLANK_SYMBOL;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s7 <= 1'b0;
		else if (en7)
			vld_s7 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en7)
			frame_s7 <= frame;
	end

	assign out_valid = vld_s7;
	assign out_data  = frame_s7;

endmodule

### design/nsd_serial.sv
module nsd_serial (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [2:0]      count,
	input  logic            in_valid,
	output logic            in_ready,
	input  nsd_pkg::frame_t in_data,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [2:0]      digit_index,
	output logic [7:0]      segment_code,
	output logic [3:0]      symbol_code,
	output logic            separator_on,
	output logic            last_digit
);

	nsd_pkg::frame_t  frame_q;
	logic             frame_vld_q;
	logic [2:0]       idx_q;
	logic             out_fire;
	logic             last;
	logic [3:0]       sym;
	logic             sep;

	assign out_fire = frame_vld_q && !out_stall;
	assign last     = (idx_q == (count - 3'd1));
	// take the next frame once the last word of this one goes out
	assign in_ready = !frame_vld_q || (out_fire && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_vld_q <= 1'b0;
			idx_q       <= 3'd0;
		end else if (in_ready) begin
			frame_vld_q <= in_valid;
			idx_q       <= 3'd0;
		end else if (out_fire) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			frame_q <= in_data;
	end

	// pick the current position and encode it
	assign sym = frame_q.sym[idx_q];
	assign sep = frame_q.sep[idx_q];

	assign out_valid    = frame_vld_q;
	assign digit_index  = idx_q;
	assign symbol_code  = sym;
	assign separator_on = sep;
	assign segment_code = {sep, nsd_pkg::seg_of(sym)};
	assign last_digit   = last;

endmodule

### design/number_to_seven_segment_digits.sv
// Number to seven-segment digits.
// Input channel (in_valid / in_stall): one display request per word: a time pair
// shown as MM:SS, a value modulo 10000 or 1000000, or a clear. Output channel
// (out_valid / out_stall): one word per display position, left to right, with
// the active-low segment code, the symbol, the separator flag and a flag on the
// last position. cfg_wr_en / cfg_wr_data set the number of positions (4..6,
// out-of-range values held at the nearest end); write it only while idle.
// The first digit of a request is offered once it has passed the seven pipeline
// stages and the frame register of the serializer. The serializer sends one digit
// per cycle while out_stall is low and takes the next frame as the last digit of
// the current one goes out; the pipeline ahead of it takes a request each cycle
// while it has room, so requests queue up behind a frame that is being sent.
// Reset empties the pipeline and sets the digit count to 4.
// A stall on the output holds the current digit; the pipeline fills behind it
// and then raises in_stall. Nothing is lost or repeated.
module number_to_seven_segment_digits (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [31:0] number_value,
	input  logic [7:0]  high_pair,
	input  logic [7:0]  low_pair,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  digit_index,
	output logic [7:0]  segment_code,
	output logic [3:0]  symbol_code,
	output logic        separator_on,
	output logic        last_digit
);

	logic [2:0]         count_q;
	nsd_pkg::request_t  req_word;
	logic               in_ready;
	logic               red_valid, red_ready;
	nsd_pkg::reduced_t  red_data;
	logic               dig_valid, dig_ready;
	nsd_pkg::digits_t   dig_data;
	logic               frm_valid, frm_ready;
	nsd_pkg::frame_t    frm_data;

	// hold the digit count, clamped on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			count_q <= nsd_pkg::COUNT_MIN;
		else if (cfg_wr_en) begin
			if (cfg_wr_data < nsd_pkg::COUNT_MIN)
				count_q <= nsd_pkg::COUNT_MIN;
			else if (cfg_wr_data > nsd_pkg::COUNT_MAX)
				count_q <= nsd_pkg::COUNT_MAX;
			else
				count_q <= cfg_wr_data;
		end
	end

	assign req_word.req          = nsd_pkg::req_t'(req_type);
	assign req_word.number_value = number_value;
	assign req_word.high_pair    = high_pair;
	assign req_word.low_pair     = low_pair;
	assign in_stall              = !in_ready;

	nsd_reduce u_reduce (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (req_word),
		.out_valid (red_valid),
		.out_ready (red_ready),
		.out_data  (red_data)
	);

	nsd_split u_split (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (red_valid),
		.in_ready  (red_ready),
		.in_data   (red_data),
		.out_valid (dig_valid),
		.out_ready (dig_ready),
		.out_data  (dig_data)
	);

	nsd_format u_format (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dig_valid),
		.in_ready  (dig_ready),
		.in_data   (dig_data),
		.out_valid (frm_valid),
		.out_ready (frm_ready),
		.out_data  (frm_data)
	);

	nsd_serial u_serial (
		.clk          (clk),
		.arst_n       (arst_n),
		.count        (count_q),
		.in_valid     (frm_valid),
		.in_ready     (frm_ready),
		.in_data      (frm_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.digit_index  (digit_index),
		.segment_code (segment_code),
		.symbol_code  (symbol_code),
		.separator_on (separator_on),
		.last_digit   (last_digit)
	);

endmodule
